// ===== hdl/tmgd_pkg.sv =====
// tmgd_pkg: shared constants for the trimmed-mean gas detector.
// Holds sample, accumulator and reciprocal-divide sizes and the kind codes.
// No dependencies.
`default_nettype none

package tmgd_pkg;

  localparam int SAMPLE_W   = 12;
  localparam int SAMPLE_MAX = (1 << SAMPLE_W) - 1;
  localparam int MARGIN_RST = 20;

  localparam int WINDOW    = 24;
  localparam int CAL_COUNT = 100;
  localparam int TRIM_DIV  = WINDOW - 2;

  localparam int WSUM_W = $clog2(WINDOW * SAMPLE_MAX + 1);
  localparam int CSUM_W = $clog2(CAL_COUNT * SAMPLE_MAX + 1);
  localparam int WCNT_W = $clog2(WINDOW + 1);
  localparam int CCNT_W = $clog2(CAL_COUNT + 1);
  localparam int DIV_W  = (WSUM_W > CSUM_W) ? WSUM_W : CSUM_W;

  localparam int WIN_SHIFT = DIV_W + $clog2(TRIM_DIV);
  localparam int CAL_SHIFT = DIV_W + $clog2(CAL_COUNT);
  localparam int MUL_W     = DIV_W + 1;
  localparam int PROD_W    = DIV_W + MUL_W + SAMPLE_W;

  localparam longint unsigned WIN_RECIP =
    ((64'd1 << WIN_SHIFT) + 64'(TRIM_DIV) - 64'd1) / 64'(TRIM_DIV);
  localparam longint unsigned CAL_RECIP =
    ((64'd1 << CAL_SHIFT) + 64'(CAL_COUNT) - 64'd1) / 64'(CAL_COUNT);

  localparam logic [MUL_W-1:0] WIN_MUL = WIN_RECIP[MUL_W-1:0];
  localparam logic [MUL_W-1:0] CAL_MUL = CAL_RECIP[MUL_W-1:0];

  localparam logic OP_MEAS   = 1'b0;
  localparam logic OP_CAL    = 1'b1;
  localparam logic KIND_MEAS = 1'b0;
  localparam logic KIND_CAL  = 1'b1;

  localparam int IN_DATA_W  = 16;
  localparam int OUT_DATA_W = 32;

endpackage

`default_nettype wire

// ===== hdl/trimmed_mean_gas_detector_top.sv =====
// trimmed_mean_gas_detector_top: window/calibration accumulators, reciprocal
// divide and threshold compare for a 12-bit gas sensor stream.
// Depends on tmgd_pkg.
//
//  channel | dir | beat contents
//  in_     | in  | tuser: operation; tdata[11:0]: sample
//  out_    | out | tuser: report_kind; tdata: level_mean, gas_level, gas_present
//  cfg_    | in  | data[11:0]: detect_margin, always ready
//
// One sample beat per cycle while in_tready is high. A completing sample's
// report passes the sum/trim stage, the shared reciprocal multiplier stage
// and the compare stage into the output register. in_tready falls only
// when all three stages are full and out_tready is low. Synchronous active-low
// reset clears accumulators, baseline, margin (to 20) and all stage valids.
`default_nettype none

module trimmed_mean_gas_detector_top (
  input  wire                               clk,
  input  wire                               rst_n,
  input  wire                               in_tvalid,
  output logic                              in_tready,
  input  wire  [tmgd_pkg::IN_DATA_W-1:0]    in_tdata,   // [11:0] sample
  input  wire                               in_tuser,   // [0] operation
  output logic                              out_tvalid,
  input  wire                               out_tready,
  output logic [tmgd_pkg::OUT_DATA_W-1:0]   out_tdata,  // [11:0] level_mean,
                                                        // [23:12] gas_level,
                                                        // [24] gas_present
  output logic                              out_tuser,  // [0] report_kind
  input  wire                               cfg_valid,
  output logic                              cfg_ready,
  input  wire  [tmgd_pkg::SAMPLE_W-1:0]     cfg_data    // [11:0] detect_margin
);
  import tmgd_pkg::*;

  logic [SAMPLE_W-1:0] margin_r;
  logic [SAMPLE_W-1:0] baseline_r;

  logic [WSUM_W-1:0]   win_sum_r, win_sum_nxt;
  logic [SAMPLE_W-1:0] win_min_r, win_min_nxt;
  logic [SAMPLE_W-1:0] win_max_r, win_max_nxt;
  logic [WCNT_W-1:0]   win_cnt_r, win_cnt_nxt;
  logic [CSUM_W-1:0]   cal_sum_r, cal_sum_nxt;
  logic [CCNT_W-1:0]   cal_cnt_r, cal_cnt_nxt;

  logic                p1_v_r, p1_v_nxt;
  logic                p1_kind_r, p1_kind_nxt;
  logic [DIV_W-1:0]    p1_num_r, p1_num_nxt;
  logic                p2_v_r, p2_v_nxt;
  logic                p2_kind_r;
  logic [SAMPLE_W-1:0] p2_quo_r, p2_quo_nxt;
  logic                out_v_r, out_v_nxt;
  logic                out_kind_r;
  logic [SAMPLE_W-1:0] out_mean_r, out_mean_nxt;
  logic [SAMPLE_W-1:0] out_level_r, out_level_nxt;
  logic                out_present_r, out_present_nxt;

  logic                accept;
  logic                out_ld, p2_ld, p1_ld;
  logic [SAMPLE_W-1:0] samp;
  logic [WSUM_W-1:0]   win_sum_add, trimmed;
  logic [SAMPLE_W-1:0] smin, smax;
  logic [CSUM_W-1:0]   cal_sum_add;
  logic                win_done, cal_done;
  logic [MUL_W-1:0]    recip;
  logic [PROD_W-1:0]   prod;
  logic [SAMPLE_W:0]   thresh;

  assign samp      = in_tdata[SAMPLE_W-1:0];
  assign out_ld    = p2_v_r && (!out_v_r || out_tready);
  assign p2_ld     = p1_v_r && (!p2_v_r || out_ld);
  assign p1_ld     = accept && (win_done || cal_done);
  assign in_tready = !p1_v_r || p2_ld;
  assign accept    = in_tvalid && in_tready;
  assign cfg_ready = 1'b1;

  // stage 1: accumulate, trim
  always_comb begin
    win_sum_add = win_sum_r + WSUM_W'(samp);
    smin        = (samp < win_min_r) ? samp : win_min_r;
    smax        = (samp > win_max_r) ? samp : win_max_r;
    trimmed     = win_sum_add - WSUM_W'(smin) - WSUM_W'(smax);
    cal_sum_add = cal_sum_r + CSUM_W'(samp);
    win_done    = (in_tuser == OP_MEAS) && (win_cnt_r == WCNT_W'(WINDOW - 1));
    cal_done    = (in_tuser == OP_CAL) && (cal_cnt_r == CCNT_W'(CAL_COUNT - 1));

    win_sum_nxt = win_sum_r;
    win_min_nxt = win_min_r;
    win_max_nxt = win_max_r;
    win_cnt_nxt = win_cnt_r;
    cal_sum_nxt = cal_sum_r;
    cal_cnt_nxt = cal_cnt_r;
    if (accept && in_tuser == OP_MEAS) begin
      if (win_done) begin
        win_sum_nxt = '0;
        win_min_nxt = SAMPLE_W'(SAMPLE_MAX);
        win_max_nxt = '0;
        win_cnt_nxt = '0;
      end else begin
        win_sum_nxt = win_sum_add;
        win_min_nxt = smin;
        win_max_nxt = smax;
        win_cnt_nxt = win_cnt_r + WCNT_W'(1);
      end
    end
    if (accept && in_tuser == OP_CAL) begin
      if (cal_done) begin
        cal_sum_nxt = '0;
        cal_cnt_nxt = '0;
      end else begin
        cal_sum_nxt = cal_sum_add;
        cal_cnt_nxt = cal_cnt_r + CCNT_W'(1);
      end
    end

    p1_v_nxt    = p1_ld || (p1_v_r && !p2_ld);
    p1_kind_nxt = cal_done ? KIND_CAL : KIND_MEAS;
    p1_num_nxt  = cal_done ? DIV_W'(cal_sum_add) : DIV_W'(trimmed);
  end

  // stage 2: divide by constant through reciprocal multiply
  always_comb begin
    recip      = (p1_kind_r == KIND_CAL) ? CAL_MUL : WIN_MUL;
    prod       = PROD_W'(p1_num_r) * PROD_W'(recip);
    p2_quo_nxt = (p1_kind_r == KIND_CAL) ? prod[CAL_SHIFT +: SAMPLE_W]
                                         : prod[WIN_SHIFT +: SAMPLE_W];
    p2_v_nxt   = p2_ld || (p2_v_r && !out_ld);
  end

  // stage 3: threshold compare
  always_comb begin
    thresh          = {1'b0, baseline_r} + {1'b0, margin_r};
    out_mean_nxt    = p2_quo_r;
    out_present_nxt = (p2_kind_r == KIND_MEAS) && ({1'b0, p2_quo_r} > thresh);
    out_level_nxt   = out_present_nxt ? (p2_quo_r - baseline_r) : '0;
    out_v_nxt       = out_ld || (out_v_r && !out_tready);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      margin_r   <= SAMPLE_W'(MARGIN_RST);
      baseline_r <= '0;
      win_sum_r  <= '0;
      win_min_r  <= SAMPLE_W'(SAMPLE_MAX);
      win_max_r  <= '0;
      win_cnt_r  <= '0;
      cal_sum_r  <= '0;
      cal_cnt_r  <= '0;
      p1_v_r     <= 1'b0;
      p2_v_r     <= 1'b0;
      out_v_r    <= 1'b0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        margin_r <= cfg_data;
      end
      if (out_ld && p2_kind_r == KIND_CAL) begin
        baseline_r <= p2_quo_r;
      end
      win_sum_r <= win_sum_nxt;
      win_min_r <= win_min_nxt;
      win_max_r <= win_max_nxt;
      win_cnt_r <= win_cnt_nxt;
      cal_sum_r <= cal_sum_nxt;
      cal_cnt_r <= cal_cnt_nxt;
      p1_v_r    <= p1_v_nxt;
      p2_v_r    <= p2_v_nxt;
      out_v_r   <= out_v_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (p1_ld) begin
      p1_kind_r <= p1_kind_nxt;
      p1_num_r  <= p1_num_nxt;
    end
    if (p2_ld) begin
      p2_kind_r <= p1_kind_r;
      p2_quo_r  <= p2_quo_nxt;
    end
    if (out_ld) begin
      out_kind_r    <= p2_kind_r;
      out_mean_r    <= out_mean_nxt;
      out_level_r   <= out_level_nxt;
      out_present_r <= out_present_nxt;
    end
  end

  assign out_tvalid = out_v_r;
  assign out_tuser  = out_kind_r;
  assign out_tdata  = OUT_DATA_W'({out_present_r, out_level_r, out_mean_r});

endmodule

`default_nettype wire
